// File: design/kfwrl_pkg.sv
// Shared types and constants for the keyed fixed-window rate limiter.
package kfwrl_pkg;

   localparam int unsigned KEY_W   = 64;
   localparam int unsigned TIME_W  = 48;
   localparam int unsigned WORD_W  = 32;

   typedef enum logic [0:0] {
      CSR_MAX_PER_WINDOW = 1'b0,
      CSR_WINDOW_LENGTH  = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIVIDE,
      BK_PRUNE,
      BK_LOOKUP,
      BK_UPDATE
   } back_state_type;

   // One request as it sits in the queue between front and back.
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [TIME_W-1:0] now;
      logic              prune;
   } job_type;

endpackage

// File: design/keyed_fixed_window_rate_limiter.sv
// Top level of the keyed fixed-window rate limiter.
// A request passes the queue, the 48-step divider, an idle prune over the table on every
// PRUNE_EVERY-th request, then a walk over the table one entry at a time and the update.
// The back end takes a new request only once it is through with the last; meanwhile the
// queue holds further requests, and busy is raised while it is full.
// Reset is synchronous and active high; it empties the table and queue and restores registers.
// The receiver cannot stall: each result is shown for exactly one cycle.
module keyed_fixed_window_rate_limiter #(
   parameter int unsigned TABLE_DEPTH  = 16,
   parameter int unsigned PRUNE_EVERY  = 256,
   parameter int unsigned IDLE_WINDOWS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_key,
   input  logic [47:0] req_now_time,
   output logic        rsp_valid,
   output logic        rsp_allowed,
   output logic        rsp_table_full,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_data
);

   // Configuration registers; a write beat lands on the register named by csr_index.
   logic [31:0] max_per_window_ff;
   logic [31:0] window_length_ff;

   // The front queue holds accepted requests while the back end works on one.
   logic               job_valid, job_take;
   kfwrl_pkg::job_type job;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_per_window_ff <= 32'd0;
         window_length_ff  <= 32'd1;
      end else if (csr_valid && csr_ready) begin
         case (kfwrl_pkg::csr_index_type'(csr_index))
            kfwrl_pkg::CSR_MAX_PER_WINDOW: max_per_window_ff <= csr_data;
            kfwrl_pkg::CSR_WINDOW_LENGTH:  window_length_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   kfwrl_front #(.PRUNE_EVERY(PRUNE_EVERY), .QUEUE_DEPTH(2)) u_front (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_key(req_key), .req_now_time(req_now_time),
      .job_valid(job_valid), .job(job), .job_take(job_take)
   );

   // The back end divides, optionally prunes, walks the table and answers.
   kfwrl_back #(.TABLE_DEPTH(TABLE_DEPTH), .IDLE_WINDOWS(IDLE_WINDOWS)) u_back (
      .clock(clock), .reset(reset), .job_valid(job_valid), .job(job),
      .job_take(job_take), .max_per_window(max_per_window_ff),
      .window_length(window_length_ff), .rsp_valid(rsp_valid),
      .rsp_allowed(rsp_allowed), .rsp_table_full(rsp_table_full)
   );

`ifndef ASSERT_OFF
   a_len_reset: assert property (@(posedge clock) $past(reset) |-> window_length_ff == 32'd1)
      else $error("window length not restored");
   a_full_only_on_rsp: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> $stable(rsp_table_full) || $past(rsp_valid))
      else $error("table_full changed without a beat");
   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      csr_valid && csr_index == 1'b0 |=> max_per_window_ff == $past(csr_data))
      else $error("max_per_window write lost");
`endif

endmodule

// File: design/kfwrl_front.sv
// Front part: takes requests, counts them towards the next prune and queues them.
module kfwrl_front #(
   parameter int unsigned PRUNE_EVERY = 256,
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [63:0]            req_key,
   input  logic [47:0]            req_now_time,
   output logic                   job_valid,
   output kfwrl_pkg::job_type     job,
   input  logic                   job_take
);

   localparam int unsigned TALLY_W = (PRUNE_EVERY > 1) ? $clog2(PRUNE_EVERY) : 1;
   localparam int unsigned PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned CNT_W   = $clog2(QUEUE_DEPTH + 1);

   kfwrl_pkg::job_type queue_mem [QUEUE_DEPTH];
   logic [TALLY_W-1:0] tally_ff, tally_in;
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               push, pop, tally_wrap;

   assign busy       = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push       = start && !busy;
   assign job_valid  = (count_ff != '0);
   assign pop        = job_take && job_valid;
   assign job        = queue_mem[rd_ptr_ff];
   assign tally_wrap = (tally_ff == TALLY_W'(PRUNE_EVERY - 1));

   always_comb begin
      tally_in = tally_ff;
      if (push) begin
         tally_in = tally_wrap ? '0 : tally_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_mem[wr_ptr_ff] <= '{key: req_key, now: req_now_time, prune: tally_wrap};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tally_ff  <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         tally_ff <= tally_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CNT_W'(push) - CNT_W'(pop);
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      busy |-> !push)
      else $error("push into full queue");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");
`endif

endmodule

// File: design/kfwrl_divider.sv
// Restoring divider, one quotient bit per cycle, yields the low 32 quotient bits.
module kfwrl_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        go,
   input  logic [47:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] quotient
);

   logic [47:0] quo_ff;
   logic [32:0] rem_ff;
   logic [31:0] dvs_ff;
   logic [5:0]  step_ff;
   logic        run_ff;
   logic [32:0] trial;
   logic [32:0] shifted;

   assign shifted  = {rem_ff[31:0], quo_ff[47]};
   assign trial    = shifted - {1'b0, dvs_ff};
   assign quotient = quo_ff[31:0];
   assign done     = run_ff && (step_ff == 6'd0);

   always_ff @(posedge clock) begin
      if (go) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= (divisor == '0) ? 32'd1 : divisor;
      end else if (run_ff && step_ff != 6'd0) begin
         if (!trial[32]) begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[46:0], 1'b1};
         end else begin
            rem_ff <= shifted;
            quo_ff <= {quo_ff[46:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         step_ff <= '0;
      end else if (go) begin
         run_ff  <= 1'b1;
         step_ff <= 6'd48;
      end else if (run_ff) begin
         if (step_ff == 6'd0) begin
            run_ff <= 1'b0;
         end else begin
            step_ff <= step_ff - 1'b1;
         end
      end
   end

endmodule

// File: design/kfwrl_back.sv
// Back part: works out the window, prunes, walks the table and answers.
module kfwrl_back #(
   parameter int unsigned TABLE_DEPTH  = 16,
   parameter int unsigned IDLE_WINDOWS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               job_valid,
   input  kfwrl_pkg::job_type job,
   output logic               job_take,
   input  logic [31:0]        max_per_window,
   input  logic [31:0]        window_length,
   output logic               rsp_valid,
   output logic               rsp_allowed,
   output logic               rsp_table_full
);

   localparam int unsigned IDX_W  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned IW_W   = $clog2(IDLE_WINDOWS) + 1;
   localparam int unsigned TTL_W  = 32 + IW_W;

   kfwrl_pkg::back_state_type state_ff, state_in;

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [63:0] key_mem   [TABLE_DEPTH];
   logic [31:0] win_mem   [TABLE_DEPTH];
   logic [31:0] cnt_mem   [TABLE_DEPTH];
   logic [47:0] last_mem  [TABLE_DEPTH];

   kfwrl_pkg::job_type job_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic               hit_ff, free_ff;
   logic [IDX_W-1:0]   hit_idx_ff, free_idx_ff;
   logic [31:0]        win_ff;
   logic [TTL_W-1:0]   ttl_ff;
   logic               div_go, div_done;
   logic [31:0]        div_q;
   logic               last_idx;
   logic [48:0]        age;
   logic               rsp_valid_ff, rsp_allowed_ff, rsp_full_ff;

   // The divider is started on the edge that takes the job, so it reads the queue head.
   kfwrl_divider u_div (
      .clock(clock), .reset(reset), .go(div_go), .dividend(job.now),
      .divisor(window_length), .done(div_done), .quotient(div_q)
   );

   assign last_idx = (idx_ff == IDX_W'(TABLE_DEPTH - 1));
   assign age      = {1'b0, job_ff.now} - {1'b0, last_mem[idx_ff]};
   assign job_take = (state_ff == kfwrl_pkg::BK_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_allowed    = rsp_allowed_ff;
   assign rsp_table_full = rsp_full_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kfwrl_pkg::BK_IDLE:   if (job_valid) state_in = kfwrl_pkg::BK_DIVIDE;
         kfwrl_pkg::BK_DIVIDE: if (div_done)
            state_in = job_ff.prune ? kfwrl_pkg::BK_PRUNE : kfwrl_pkg::BK_LOOKUP;
         kfwrl_pkg::BK_PRUNE:  if (last_idx) state_in = kfwrl_pkg::BK_LOOKUP;
         kfwrl_pkg::BK_LOOKUP: if (last_idx) state_in = kfwrl_pkg::BK_UPDATE;
         kfwrl_pkg::BK_UPDATE: state_in = kfwrl_pkg::BK_IDLE;
         default:              state_in = kfwrl_pkg::BK_IDLE;
      endcase
   end

   always_comb begin
      div_go = 1'b0;
      unique case (state_ff)
         kfwrl_pkg::BK_IDLE: div_go = job_valid;
         default:            div_go = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= kfwrl_pkg::BK_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= 1'b0;
         if (state_ff == kfwrl_pkg::BK_PRUNE) begin
            if (valid_ff[idx_ff] && !age[48]
                && {{(48-TTL_W){1'b0}}, ttl_ff} < age[47:0]) begin
               valid_ff[idx_ff] <= 1'b0;
            end
         end
         if (state_ff == kfwrl_pkg::BK_UPDATE) begin
            rsp_valid_ff <= 1'b1;
            if (!hit_ff && free_ff) begin
               valid_ff[free_idx_ff] <= 1'b1;
            end
         end
      end
   end

   // Datapath: index walk, lookup results, table writes.
   always_ff @(posedge clock) begin
      logic [IDX_W-1:0] slot;
      logic [31:0]      cur_win, cur_cnt;
      slot    = hit_ff ? hit_idx_ff : free_idx_ff;
      cur_win = hit_ff ? win_mem[slot] : 32'd0;
      cur_cnt = hit_ff ? cnt_mem[slot] : 32'd0;
      unique case (state_ff)
         kfwrl_pkg::BK_IDLE: begin
            job_ff <= job;
         end
         kfwrl_pkg::BK_DIVIDE: begin
            idx_ff  <= '0;
            hit_ff  <= 1'b0;
            free_ff <= 1'b0;
            win_ff  <= div_q;
            ttl_ff  <= TTL_W'(((window_length == '0) ? 32'd1 : window_length))
                       * TTL_W'(IDLE_WINDOWS);
         end
         kfwrl_pkg::BK_PRUNE: begin
            idx_ff <= last_idx ? '0 : idx_ff + 1'b1;
         end
         kfwrl_pkg::BK_LOOKUP: begin
            idx_ff <= last_idx ? '0 : idx_ff + 1'b1;
            if (valid_ff[idx_ff] && key_mem[idx_ff] == job_ff.key && !hit_ff) begin
               hit_ff     <= 1'b1;
               hit_idx_ff <= idx_ff;
            end
            if (!valid_ff[idx_ff] && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= idx_ff;
            end
         end
         kfwrl_pkg::BK_UPDATE: begin
            rsp_full_ff    <= !hit_ff && !free_ff;
            rsp_allowed_ff <= 1'b0;
            if (hit_ff || free_ff) begin
               key_mem[slot]  <= job_ff.key;
               last_mem[slot] <= job_ff.now;
               if (cur_win != win_ff) begin
                  win_mem[slot]  <= win_ff;
                  cnt_mem[slot]  <= 32'd1;
                  rsp_allowed_ff <= 1'b1;
               end else if (cur_cnt < max_per_window) begin
                  win_mem[slot]  <= cur_win;
                  cnt_mem[slot]  <= cur_cnt + 32'd1;
                  rsp_allowed_ff <= 1'b1;
               end else begin
                  win_mem[slot]  <= cur_win;
                  cnt_mem[slot]  <= cur_cnt;
               end
            end
         end
         default: begin
            idx_ff <= '0;
         end
      endcase
   end

`ifndef ASSERT_OFF
   a_full_denies: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_table_full |-> !rsp_allowed)
      else $error("table full yet allowed");
   a_rsp_after_update: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff) == kfwrl_pkg::BK_UPDATE)
      else $error("response without update");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      job_take |-> state_ff == kfwrl_pkg::BK_IDLE)
      else $error("job taken while working");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for the keyed fixed-window rate limiter.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned DEPTH     = 16;
   localparam int unsigned PRUNE_N   = 256;
   localparam int unsigned IDLE_WINS = 4;
   localparam int unsigned RANDOM_ITEMS = 1230;

   // One expected beat on the result side.
   typedef struct {
      logic allowed;
      logic table_full;
   } verdict_type;

   // The scoreboard keeps its own copy of the table and registers. It works out the
   // verdict of every accepted request and queues it until the strobed result arrives.
   class limiter_scoreboard;
      logic [kfwrl_pkg::KEY_W-1:0]  slot_key [DEPTH];
      logic [kfwrl_pkg::WORD_W-1:0] slot_window [DEPTH];
      logic [kfwrl_pkg::WORD_W-1:0] slot_count [DEPTH];
      logic [kfwrl_pkg::TIME_W-1:0] slot_seen [DEPTH];
      bit                slot_used [DEPTH];
      int unsigned       since_prune;
      logic [kfwrl_pkg::WORD_W-1:0] limit;
      logic [kfwrl_pkg::WORD_W-1:0] win_len;
      verdict_type       pending[$];
      int unsigned       errors;
      int unsigned       n_allowed, n_denied, n_full;

      function new();
         for (int i = 0; i < DEPTH; i++) slot_used[i] = 0;
         since_prune = 0;
         limit = '0;
         win_len = 32'd1;
         errors = 0;
         n_allowed = 0;
         n_denied = 0;
         n_full = 0;
      endfunction

      function void write_reg(kfwrl_pkg::csr_index_type idx,
                              logic [kfwrl_pkg::WORD_W-1:0] value);
         if (idx == kfwrl_pkg::CSR_MAX_PER_WINDOW) limit = value;
         else win_len = value;
      endfunction

      // Called for every request beat taken by the block.
      function void note_request(logic [kfwrl_pkg::KEY_W-1:0] key,
                                 logic [kfwrl_pkg::TIME_W-1:0] now);
         logic [63:0] len, ttl;
         logic [kfwrl_pkg::WORD_W-1:0] win;
         int slot;
         verdict_type v;
         len = (win_len == 0) ? 64'd1 : {32'd0, win_len};
         win = 32'((64'(now)) / len);
         ttl = len * IDLE_WINS;
         slot = -1;
         v.allowed = 1'b0;
         v.table_full = 1'b0;
         since_prune++;
         if (since_prune >= PRUNE_N) begin
            since_prune = 0;
            // Entries whose last access lies in the future are kept.
            for (int i = 0; i < DEPTH; i++)
               if (slot_used[i] && now >= slot_seen[i] && 64'(now - slot_seen[i]) > ttl)
                  slot_used[i] = 0;
         end
         for (int i = 0; i < DEPTH; i++)
            if (slot < 0 && slot_used[i] && slot_key[i] == key) slot = i;
         if (slot < 0) begin
            for (int i = 0; i < DEPTH; i++)
               if (slot < 0 && !slot_used[i]) slot = i;
            if (slot >= 0) begin
               slot_used[slot] = 1;
               slot_key[slot] = key;
               slot_window[slot] = '0;
               slot_count[slot] = '0;
            end
         end
         if (slot < 0) begin
            v.table_full = 1'b1;
            n_full++;
         end else begin
            slot_seen[slot] = now;
            if (slot_window[slot] != win) begin
               slot_window[slot] = win;
               slot_count[slot] = 32'd1;
               v.allowed = 1'b1;
            end else if (slot_count[slot] < limit) begin
               slot_count[slot] = slot_count[slot] + 32'd1;
               v.allowed = 1'b1;
            end
            if (v.allowed) n_allowed++;
            else n_denied++;
         end
         pending.push_back(v);
      endfunction

      function void check_result(logic allowed, logic table_full);
         verdict_type v;
         if (pending.size() == 0) begin
            $error("result beat with nothing outstanding");
            errors++;
            return;
         end
         v = pending.pop_front();
         if (allowed !== v.allowed) begin
            $error("allowed: expected %0b, got %0b", v.allowed, allowed);
            errors++;
         end
         if (table_full !== v.table_full) begin
            $error("table_full: expected %0b, got %0b", v.table_full, table_full);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [63:0] req_key = '0;
   logic [47:0] req_now_time = '0;
   logic        rsp_valid;
   logic        rsp_allowed;
   logic        rsp_table_full;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   limiter_scoreboard sb = new();

   // Keys of the current phase; a small pool keeps keys repeating so that windows fill up.
   logic [63:0] key_pool[$];
   logic [47:0] clock_now;
   int unsigned items_sent = 0;
   bit          quiet_tail = 0;

   keyed_fixed_window_rate_limiter dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_key(req_key), .req_now_time(req_now_time),
      .rsp_valid(rsp_valid), .rsp_allowed(rsp_allowed), .rsp_table_full(rsp_table_full),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Results are strobed for one cycle and cannot be held off, so every strobe is a beat.
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_result(rsp_allowed, rsp_table_full);
   end

   // Offers one request and leaves start high once it is taken. A random burst of idle
   // cycles may follow, except in the quiet tail of the run where requests go back to back.
   task automatic send_request(input logic [63:0] key, input logic [47:0] now);
      req_key <= key;
      req_now_time <= now;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_request(key, now);
      items_sent++;
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   // Drops start and waits until every outstanding verdict has come back, so the block
   // is idle before a register is touched.
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input kfwrl_pkg::csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, value);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_limits(input logic [31:0] max_count, input logic [31:0] length);
      drain();
      write_csr(kfwrl_pkg::CSR_MAX_PER_WINDOW, max_count);
      write_csr(kfwrl_pkg::CSR_WINDOW_LENGTH, length);
   endtask

   // A random phase: fresh key pool, a random starting time, then mostly small forward
   // steps with the odd large jump and the odd step backwards in time.
   task automatic random_phase(input logic [31:0] max_count, input logic [31:0] length,
                               input int unsigned count, input int unsigned pool_size);
      logic [63:0] step;
      logic [63:0] key;
      set_limits(max_count, length);
      key_pool.delete();
      for (int i = 0; i < pool_size; i++) key_pool.push_back({$urandom, $urandom});
      clock_now = 48'({$urandom, $urandom});
      if ($urandom_range(0, 1) == 0) clock_now = 48'(clock_now >> 24);
      for (int n = 0; n < count; n++) begin
         if (RANDOM_ITEMS + 25 - items_sent < 150) quiet_tail = 1;
         case ($urandom_range(0, 31))
            0: clock_now = clock_now - 48'($urandom_range(1, 1000));
            1: clock_now = 48'({$urandom, $urandom});
            2, 3, 4, 5, 6, 7: ;
            default: begin
               if (length < 1000) step = $urandom_range(0, 3 * length);
               else step = {$urandom_range(0, 7), $urandom};
               clock_now = clock_now + 48'(step);
            end
         endcase
         if ($urandom_range(0, 15) == 0) key = {$urandom, $urandom};
         else key = key_pool[$urandom_range(0, pool_size - 1)];
         send_request(key, clock_now);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. A limit of zero with a new key in window zero denies; the next
      // window then allows. Extreme keys and times, time going backwards, and a full table.
      set_limits(32'd0, 32'd1);
      send_request(64'd0, 48'd0);
      send_request(64'd0, 48'd0);
      send_request(64'd0, 48'd1);
      send_request(64'h7FFF_FFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      send_request(64'h8000_0000_0000_0000, 48'hFFFF_FFFF_FFFF);
      send_request(64'hFFFF_FFFF_FFFF_FFFF, 48'h0000_0001_0000);
      send_request(64'h8000_0000_0000_0000, 48'h0000_0000_0005);
      set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(64'd0, 48'h0000_FFFF_FFFE);
      send_request(64'd0, 48'hFFFF_FFFF_FFFF);
      set_limits(32'd1, 32'd10);
      for (int i = 1; i <= 14; i++) send_request(64'(i) * 64'h0101_0101_0101_0101, 48'd100);
      send_request(64'h1234_5678_9ABC_DEF0, 48'd100);
      send_request(64'd1, 48'd100);

      // Random part over several register settings, extremes included.
      random_phase(32'd2, 32'd10, 200, 12);
      random_phase(32'd0, 32'd1, 150, 20);
      random_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 150, 6);
      random_phase(32'd1, 32'd1, 150, 16);
      random_phase(32'd3, 32'd50, 200, 24);
      random_phase($urandom_range(1, 6), $urandom_range(2, 40), 180, 10);
      random_phase(32'd4, 32'd7, 200, 8);

      drain();
      repeat (200) @(posedge clock);
      $display("Sent %0d requests over ten register settings: %0d allowed, %0d denied,",
               items_sent, sb.n_allowed, sb.n_denied);
      $display("%0d refused on a full table; idle prunes ran every %0d requests.",
               sb.n_full, PRUNE_N);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Watchdog: the slowest legal run is far below this.
   initial begin
      #10ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
